// ----- rtl/core/smm_pkg.sv -----
package smm_pkg;

    // Matrix order and derived widths
    localparam int SIZE_N = 3;
    localparam int NUM_EL = SIZE_N * SIZE_N;
    localparam int IDX_W  = $clog2(NUM_EL);
    localparam int CNT_W  = $clog2(SIZE_N);

    // Data widths: Q16.16 operands, full-width products, exact sum of SIZE_N products
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(SIZE_N) + 1;
    localparam int FRAC_W = 16;
    localparam int SHR_W  = ACC_W - FRAC_W;

    // Command codes
    localparam logic [1:0] FUNC_LEFT  = 2'd0;
    localparam logic [1:0] FUNC_RIGHT = 2'd1;
    localparam logic [1:0] FUNC_MULT  = 2'd2;

    // Saturation limits
    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } smm_state_t;

    // Tag that travels with each MAC step down the pipeline
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last_k;
        logic             last_el;
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] j;
    } smm_tag_t;

    // Flat store index of element (r, c)
    function automatic logic [IDX_W-1:0] flat_idx(input int r, input int c);
        return IDX_W'(r * SIZE_N + c);
    endfunction

endpackage

// ----- rtl/core/square_matrix_multiply_top.sv -----
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+--------------------------
// command  | func, row, col, value                         | taken when start && !busy
// result   | out_row, out_col, product_value, saturated,   | one-cycle strobe per beat
//          | last                                          |
//
// A left or right element write leaves busy low.
// A multiply walks SIZE_N**3 MAC steps through one multiplier, one per cycle, as
// each step needs one read of each store's single read port; each element's beat
// follows its last step through the read, product, accumulator and output
// registers, and busy falls as the final beat is shown.
// Reset clears the valid bits of both stores, so unwritten elements read as zero.
// Result beats cannot be held off; each one is shown for a single cycle.
module square_matrix_multiply_top
    import smm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               func,
    input  logic [1:0]               row,
    input  logic [1:0]               col,
    input  logic signed [DATA_W-1:0] value,
    output logic                     strobe,
    output logic [1:0]               out_row,
    output logic [1:0]               out_col,
    output logic signed [DATA_W-1:0] product_value,
    output logic                     saturated,
    output logic                     last
);

    smm_state_t state_reg, state_next;

    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;

    logic [NUM_EL-1:0] lvld_reg, rvld_reg;
    logic              lrd_vld_reg, rrd_vld_reg;

    smm_tag_t tag0, tag1_reg, tag2_reg, tag3_reg;

    logic                     accept;
    logic                     in_range;
    logic                     lwe, rwe;
    logic [IDX_W-1:0]         widx;
    logic                     issue;
    logic [IDX_W-1:0]         laddr, raddr;
    logic [DATA_W-1:0]        ldata, rdata;
    logic signed [DATA_W-1:0] lop, rop;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SHR_W-1:0]  shifted;
    logic [SHR_W-32:0]        hi_bits;
    logic                     fits;
    logic                     last_step;

    logic                     strobe_reg;
    logic [1:0]               out_row_reg, out_col_reg;
    logic [DATA_W-1:0]        value_reg;
    logic                     sat_reg, last_reg;

    // Command decode
    assign accept   = start && !busy;
    assign in_range = (int'(row) < SIZE_N) && (int'(col) < SIZE_N);
    assign widx     = flat_idx(int'(row), int'(col));
    assign lwe      = accept && (func == FUNC_LEFT) && in_range;
    assign rwe      = accept && (func == FUNC_RIGHT) && in_range;
    assign issue    = (state_reg == ST_ISSUE);

    // Read addresses: left[i][k], right[k][j]
    assign laddr = flat_idx(int'(i_reg), int'(k_reg));
    assign raddr = flat_idx(int'(k_reg), int'(j_reg));

    smm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_EL)) u_left_ram (
        .clk   (clk),
        .we    (lwe),
        .waddr (widx),
        .wdata (value),
        .re    (issue),
        .raddr (laddr),
        .rdata (ldata)
    );

    smm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_EL)) u_right_ram (
        .clk   (clk),
        .we    (rwe),
        .waddr (widx),
        .wdata (value),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Step counters and sequencer
    assign last_step = (int'(i_reg) == SIZE_N - 1) && (int'(j_reg) == SIZE_N - 1)
                    && (int'(k_reg) == SIZE_N - 1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_MULT))
                begin
                    state_next = ST_ISSUE;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                if (int'(k_reg) == SIZE_N - 1)
                begin
                    k_next = '0;
                    if (int'(j_reg) == SIZE_N - 1)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
                if (last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tag3_reg.vld && tag3_reg.last_k && tag3_reg.last_el)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // Tag for the step issued this cycle
    always_comb
    begin
        tag0.vld     = issue;
        tag0.first   = (k_reg == '0);
        tag0.last_k  = (int'(k_reg) == SIZE_N - 1);
        tag0.last_el = (int'(i_reg) == SIZE_N - 1) && (int'(j_reg) == SIZE_N - 1);
        tag0.i       = i_reg;
        tag0.j       = j_reg;
    end

    // Multiply: unwritten entries read as zero
    assign lop       = lrd_vld_reg ? $signed(ldata) : '0;
    assign rop       = rrd_vld_reg ? $signed(rdata) : '0;
    assign prod_next = PROD_W'(lop) * PROD_W'(rop);

    // Accumulate at full width
    assign acc_next = (tag2_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);

    // Truncate towards minus infinity, then saturate
    assign shifted = SHR_W'(acc_reg >>> FRAC_W);
    assign hi_bits = shifted[SHR_W-1:31];
    assign fits    = (&hi_bits) || !(|hi_bits);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            lvld_reg    <= '0;
            rvld_reg    <= '0;
            lrd_vld_reg <= 1'b0;
            rrd_vld_reg <= 1'b0;
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            tag3_reg    <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (lwe)
            begin
                lvld_reg[widx] <= 1'b1;
            end
            if (rwe)
            begin
                rvld_reg[widx] <= 1'b1;
            end
            if (issue)
            begin
                lrd_vld_reg <= lvld_reg[laddr];
                rrd_vld_reg <= rvld_reg[raddr];
            end
            tag1_reg   <= tag0;
            tag2_reg   <= tag1_reg;
            tag3_reg   <= tag2_reg;
            strobe_reg <= tag3_reg.vld && tag3_reg.last_k;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (tag1_reg.vld)
        begin
            prod_reg <= prod_next;
        end
        if (tag2_reg.vld)
        begin
            acc_reg <= acc_next;
        end
        if (tag3_reg.vld && tag3_reg.last_k)
        begin
            out_row_reg <= 2'(tag3_reg.i);
            out_col_reg <= 2'(tag3_reg.j);
            sat_reg     <= !fits;
            last_reg    <= tag3_reg.last_el;
            if (fits)
            begin
                value_reg <= shifted[DATA_W-1:0];
            end
            else if (acc_reg[ACC_W-1])
            begin
                value_reg <= SAT_NEG;
            end
            else
            begin
                value_reg <= SAT_POS;
            end
        end
    end

    assign strobe        = strobe_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = $signed(value_reg);
    assign saturated     = sat_reg;
    assign last          = last_reg;

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!tag1_reg.vld && !tag2_reg.vld && !tag3_reg.vld))
        else $error("MAC pipeline busy while sequencer idle");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result beat without a multiply in flight");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> (out_row == 2'(SIZE_N - 1) && out_col == 2'(SIZE_N - 1)))
        else $error("last beat not on final element");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("busy still high at final beat");

endmodule

// ----- rtl/core/smm_ram.sv -----
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/square_matrix_multiply_top_test.sv -----
`timescale 1ns / 100ps

module square_matrix_multiply_top_test
    import smm_pkg::*;
();

    localparam int         CLK_HALF     = 5;
    localparam int         RESET_CYCLES = 12;
    localparam int         DRAIN_CYCLES = SIZE_N * SIZE_N * SIZE_N + 16;
    localparam int         TIMEOUT_NS   = 4_000_000;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         ACCUM_W      = 128;

    // One product element as it leaves the block
    typedef struct packed {
        logic [1:0]              r;
        logic [1:0]              c;
        logic signed [DATA_W-1:0] v;
        logic                    sat;
        logic                    fin;
    } product_beat_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     start         = 1'b0;
    logic [1:0]               func          = '0;
    logic [1:0]               row           = '0;
    logic [1:0]               col           = '0;
    logic signed [DATA_W-1:0] value         = '0;
    logic                     busy;
    logic                     strobe;
    logic [1:0]               out_row;
    logic [1:0]               out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                     saturated;
    logic                     last;

    // Shadow copies of the two matrices and the products still owed
    logic signed [DATA_W-1:0] left_mat  [NUM_EL];
    logic signed [DATA_W-1:0] right_mat [NUM_EL];
    product_beat_t            pending_products [$];
    int                       fail_count      = 0;
    int                       sender_idle_pct = 0;

    square_matrix_multiply_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .row           (row),
        .col           (col),
        .value         (value),
        .strobe        (strobe),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .saturated     (saturated),
        .last          (last)
    );

    always #CLK_HALF clk = ~clk;

    // Exact dot product of left row i and right column j, floored by 16 bits, clipped
    function automatic product_beat_t matrix_element(input int i, input int j);
        product_beat_t            beat;
        logic signed [ACCUM_W-1:0] acc;
        logic signed [ACCUM_W-1:0] shifted;
        acc = '0;
        for (int k = 0; k < SIZE_N; k++)
        begin
            acc += left_mat[i * SIZE_N + k] * right_mat[k * SIZE_N + j];
        end
        shifted  = acc >>> FRAC_W;
        beat.r   = i[1:0];
        beat.c   = j[1:0];
        beat.fin = (i == SIZE_N - 1) && (j == SIZE_N - 1);
        if (shifted > $signed(ACCUM_W'(32'h7FFF_FFFF)))
        begin
            beat.v   = SAT_POS;
            beat.sat = 1'b1;
        end
        else if (shifted < -$signed(ACCUM_W'(32'h8000_0000)))
        begin
            beat.v   = SAT_NEG;
            beat.sat = 1'b1;
        end
        else
        begin
            beat.v   = shifted[DATA_W-1:0];
            beat.sat = 1'b0;
        end
        return beat;
    endfunction

    // Update the shadow stores or queue a whole product run for one accepted command
    task automatic apply_command(input logic [1:0] f, input logic [1:0] r, input logic [1:0] c,
                                 input logic signed [DATA_W-1:0] v);
        if ((f == FUNC_LEFT || f == FUNC_RIGHT) && r < SIZE_N && c < SIZE_N)
        begin
            if (f == FUNC_LEFT)
                left_mat[r * SIZE_N + c] = v;
            else
                right_mat[r * SIZE_N + c] = v;
        end
        else if (f == FUNC_MULT)
        begin
            for (int i = 0; i < SIZE_N; i++)
            begin
                for (int j = 0; j < SIZE_N; j++)
                begin
                    pending_products.insert(pending_products.size(), matrix_element(i, j));
                end
            end
        end
    endtask

    // Drive one command beat on the falling edge, hold it until taken
    task automatic send_command(input logic [1:0] f, input logic [1:0] r, input logic [1:0] c,
                                input logic signed [DATA_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        func  <= f;
        row   <= r;
        col   <= c;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_command(f, r, c, v);
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result beats: each one against the oldest owed product
    always @(posedge clk)
    begin : result_check
        product_beat_t want;
        if (rst_n && strobe)
        begin
            if (pending_products.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual row %0d col %0d value %h",
                         $time, out_row, out_col, product_value);
                fail_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                compare_field("out_row", want.r, out_row);
                compare_field("out_col", want.c, out_col);
                compare_field("product_value", want.v, product_value);
                compare_field("saturated", want.sat, saturated);
                compare_field("last", want.fin, last);
            end
        end
    end

    // Mix of full-range, small, unit-scale and extreme Q16.16 values
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed(DATA_W'($urandom_range(1 << 19))) - (1 << 18);
            2: return SAT_POS;
            3: return SAT_NEG;
            4: return $signed(DATA_W'($urandom_range(1 << 21))) - (1 << 20);
            default: return '0;
        endcase
    endfunction

    // Product straight after reset: both stores read as zero
    task automatic test_cleared_stores();
        send_command(FUNC_MULT, 2'd0, 2'd0, '0);
    endtask

    // Clipping on both sides, including min times min
    task automatic test_saturation();
        send_command(FUNC_LEFT,  2'd0, 2'd0, SAT_POS);
        send_command(FUNC_RIGHT, 2'd0, 2'd0, SAT_POS);
        send_command(FUNC_LEFT,  2'd2, 2'd2, SAT_NEG);
        send_command(FUNC_RIGHT, 2'd2, 2'd2, SAT_POS);
        send_command(FUNC_LEFT,  2'd1, 2'd1, SAT_NEG);
        send_command(FUNC_RIGHT, 2'd1, 2'd1, SAT_NEG);
        send_command(FUNC_MULT,  2'd3, 2'd3, SAT_NEG);
    endtask

    // Out-of-range indices and the spare func code must leave the stores alone
    task automatic test_ignored_commands();
        send_command(FUNC_LEFT,   2'd3, 2'd0, 32'h1234_5678);
        send_command(FUNC_RIGHT,  2'd1, 2'd3, 32'h8765_4321);
        send_command(FUNC_LEFT,   2'd3, 2'd3, SAT_POS);
        send_command(FUNC_UNUSED, 2'd0, 2'd0, SAT_NEG);
        send_command(FUNC_MULT,   2'd0, 2'd0, '0);
    endtask

    // 1.0 * 1.5 minus one LSB squared: shift must floor towards minus infinity
    task automatic test_floor_shift();
        send_command(FUNC_LEFT,  2'd0, 2'd0, 32'h0001_0000);
        send_command(FUNC_RIGHT, 2'd0, 2'd0, 32'h0001_8000);
        send_command(FUNC_LEFT,  2'd0, 2'd1, 32'hFFFF_FFFF);
        send_command(FUNC_RIGHT, 2'd1, 2'd0, 32'h0000_0001);
        send_command(FUNC_MULT,  2'd1, 2'd2, '0);
    endtask

    // Mostly element loads followed by products, with some stray commands mixed in
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int                       counted;
        int                       pick;
        logic [1:0]               f;
        logic [1:0]               r;
        logic [1:0]               c;
        logic signed [DATA_W-1:0] v;
        sender_idle_pct = idle_pct;
        counted         = 0;
        while (counted < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 43)
                f = FUNC_LEFT;
            else if (pick < 86)
                f = FUNC_RIGHT;
            else if (pick < 97)
                f = FUNC_MULT;
            else
                f = FUNC_UNUSED;
            if ($urandom_range(11) == 0)
            begin
                r = 2'($urandom);
                c = 2'($urandom);
            end
            else
            begin
                r = 2'($urandom_range(SIZE_N - 1));
                c = 2'($urandom_range(SIZE_N - 1));
            end
            v = pick_value();
            send_command(f, r, c, v);
            if (f == FUNC_MULT || (f != FUNC_UNUSED && r < SIZE_N && c < SIZE_N))
                counted++;
        end
    endtask

    // Sequence of tests, then drain and verdict
    initial
    begin
        for (int n = 0; n < NUM_EL; n++)
        begin
            left_mat[n]  = '0;
            right_mat[n] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_cleared_stores();
        test_saturation();
        test_ignored_commands();
        test_floor_shift();
        test_random_traffic(0, 110);
        test_random_traffic(48, 110);
        test_random_traffic(17, 110);

        @(negedge clk);
        start <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS square_matrix_multiply_top");
        else
            $display("FAIL square_matrix_multiply_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d product beats still owed", $time, pending_products.size());
        $display("FAIL square_matrix_multiply_top");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/smm_pkg.sv
rtl/core/smm_ram.sv
rtl/core/square_matrix_multiply_top.sv
tb/square_matrix_multiply_top_test.sv
